// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl, clocked on clk with rst_n as reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GRR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grr assertion failed");

// next-cycle implication
`define GRR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grr assertion failed");

`endif

// File: rtl/grr_pkg.sv
// ----------------------------------------------------------------------------
// grr_pkg
// Shared types and constants of the grid ring rotation remap block.
// ----------------------------------------------------------------------------
package grr_pkg;

    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_DATA_WIDTH = 16;

    localparam int IDX_W   = 6;   // row / col request fields
    localparam int CRD_W   = 7;   // internal coordinates and sizes
    localparam int LEN_W   = 9;   // ring length and position
    localparam int SHIFT_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_AMOUNT = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic             oob;    // cell lies outside the memory
        logic             ring;   // cell belongs to a rotating ring
        logic [CRD_W-1:0] row;
        logic [CRD_W-1:0] col;
        logic [CRD_W-1:0] lvl;
        logic [CRD_W-1:0] h;
        logic [CRD_W-1:0] w;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] pos;
    } entry_t;

endpackage

// File: rtl/grr_ram.sv
// ----------------------------------------------------------------------------
// grr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module grr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/grr_fifo.sv
// ----------------------------------------------------------------------------
// grr_fifo
// Short request queue between the classifier and the execution engine.
// ----------------------------------------------------------------------------
module grr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [CW-1:0]    cnt_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        bump = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= bump(wptr_reg);
            end
            if (pop)
            begin
                rptr_reg <= bump(rptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign dout  = slot_reg[rptr_reg];
    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);

endmodule

// File: rtl/grr_front.sv
// ----------------------------------------------------------------------------
// grr_front
// Classifies a request: ring level, ring geometry and position on the ring.
// ----------------------------------------------------------------------------
module grr_front #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic [grr_pkg::CRD_W-1:0] num_rows,
    input  logic [grr_pkg::CRD_W-1:0] num_cols,
    input  logic                      kind,
    input  logic [grr_pkg::IDX_W-1:0] row,
    input  logic [grr_pkg::IDX_W-1:0] col,
    output grr_pkg::entry_t           ent
);
    import grr_pkg::*;

    logic [CRD_W-1:0] rr, cc, r7, c7, dr, dc, lvl, mn, h, w, ye, xe, m1, m2;
    logic             in_grid;
    logic [LEN_W-1:0] hm1, wm1;

    always_comb
    begin
        // sizes saturate at the memory bounds
        rr = (9'(num_rows) > 9'(MAX_ROWS)) ? CRD_W'(MAX_ROWS) : num_rows;
        cc = (9'(num_cols) > 9'(MAX_COLS)) ? CRD_W'(MAX_COLS) : num_cols;
        r7 = CRD_W'(row);
        c7 = CRD_W'(col);
        in_grid = (r7 < rr) && (c7 < cc);
        dr = rr - 1'b1 - r7;
        dc = cc - 1'b1 - c7;
        m1 = (r7 < c7) ? r7 : c7;
        m2 = (dr < dc) ? dr : dc;
        lvl = (m1 < m2) ? m1 : m2;
        mn = (rr < cc) ? rr : cc;
        h  = rr - {lvl[CRD_W-2:0], 1'b0};
        w  = cc - {lvl[CRD_W-2:0], 1'b0};
        ye = rr - 1'b1 - lvl;
        xe = cc - 1'b1 - lvl;
        hm1 = LEN_W'(h) - 1'b1;
        wm1 = LEN_W'(w) - 1'b1;

        ent.kind = kind;
        ent.oob  = (9'(row) >= 9'(MAX_ROWS)) || (9'(col) >= 9'(MAX_COLS));
        ent.ring = in_grid && (lvl < (mn >> 1));
        ent.row  = r7;
        ent.col  = c7;
        ent.lvl  = lvl;
        ent.h    = h;
        ent.w    = w;
        ent.len  = LEN_W'({h, 1'b0}) + LEN_W'({w, 1'b0}) - LEN_W'(4);
        // left edge, bottom, right edge, top
        if (c7 == lvl)
            ent.pos = LEN_W'(r7 - lvl);
        else if (r7 == ye)
            ent.pos = hm1 + LEN_W'(c7 - lvl);
        else if (c7 == xe)
            ent.pos = hm1 + wm1 + LEN_W'(ye - r7);
        else
            ent.pos = (hm1 << 1) + wm1 + LEN_W'(xe - c7);
    end

endmodule

// File: rtl/grr_back.sv
// ----------------------------------------------------------------------------
// grr_back
// Executes queued requests: shift modulo ring length and remap for ring reads, memory access.
// ----------------------------------------------------------------------------
module grr_back #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int DATA_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [grr_pkg::SHIFT_W-1:0] shift_amount,
    input  logic                        q_empty,
    input  grr_pkg::entry_t             q_ent,
    input  logic [DATA_WIDTH-1:0]       q_value,
    output logic                        q_pop,
    output logic                        done,
    output logic [DATA_WIDTH-1:0]       rotated_value
);
    import grr_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(SHIFT_W);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_FOLD, S_MAP, S_ADR, S_WRITE, S_READ, S_FIN
    } state_t;

    state_t              state_reg, state_next;
    entry_t              ent_reg, ent_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [SHIFT_W-1:0]  dvd_reg, dvd_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LEN_W-1:0]    q_reg, q_next;
    logic [CRD_W-1:0]    r_reg, r_next, c_reg, c_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                done_reg, done_next;
    logic [DATA_WIDTH-1:0] out_reg, out_next;

    logic [LEN_W:0]      trial;
    logic [LEN_W:0]      qsum;
    logic [LEN_W-1:0]    hm1, wm1;
    logic [CRD_W-1:0]    ye, xe;
    logic [DATA_WIDTH-1:0] rdata;
    logic                ram_we, ram_re;

    grr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (val_reg),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        val_next   = val_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        addr_next  = addr_reg;
        done_next  = 1'b0;
        out_next   = out_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;

        trial = {rem_reg, dvd_reg[SHIFT_W-1]};
        qsum  = {1'b0, ent_reg.pos} + {1'b0, ent_reg.len} - {1'b0, rem_reg};
        hm1   = LEN_W'(ent_reg.h) - 1'b1;
        wm1   = LEN_W'(ent_reg.w) - 1'b1;
        ye    = ent_reg.lvl + ent_reg.h - 1'b1;
        xe    = ent_reg.lvl + ent_reg.w - 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    ent_next = q_ent;
                    val_next = q_value;
                    r_next   = q_ent.row;
                    c_next   = q_ent.col;
                    dvd_next = shift_amount;
                    rem_next = '0;
                    cnt_next = '0;
                    if (q_ent.kind == KIND_READ && q_ent.ring)
                        state_next = S_DIV;
                    else
                        state_next = S_ADR;
                end
            end
            S_DIV:
            begin
                // restoring remainder, one dividend bit per cycle
                if (trial >= {1'b0, ent_reg.len})
                    rem_next = LEN_W'(trial - {1'b0, ent_reg.len});
                else
                    rem_next = LEN_W'(trial);
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SHIFT_W - 1))
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                if (qsum >= {1'b0, ent_reg.len})
                    q_next = LEN_W'(qsum - {1'b0, ent_reg.len});
                else
                    q_next = LEN_W'(qsum);
                state_next = S_MAP;
            end
            S_MAP:
            begin
                if (q_reg < LEN_W'(ent_reg.h))
                begin
                    r_next = ent_reg.lvl + CRD_W'(q_reg);
                    c_next = ent_reg.lvl;
                end
                else if (q_reg < hm1 + LEN_W'(ent_reg.w))
                begin
                    r_next = ye;
                    c_next = ent_reg.lvl + CRD_W'(q_reg - hm1);
                end
                else if (q_reg < hm1 + LEN_W'(ent_reg.h) + wm1)
                begin
                    r_next = ye - CRD_W'(q_reg - hm1 - wm1);
                    c_next = xe;
                end
                else
                begin
                    r_next = ent_reg.lvl;
                    c_next = xe - CRD_W'(q_reg - (hm1 << 1) - wm1);
                end
                state_next = S_ADR;
            end
            S_ADR:
            begin
                addr_next = ADDR_W'(ADDR_W'(r_reg) * ADDR_W'(MAX_COLS)) + ADDR_W'(c_reg);
                if (ent_reg.kind == KIND_WRITE)
                    state_next = S_WRITE;
                else
                    state_next = S_READ;
            end
            S_WRITE:
            begin
                ram_we     = !ent_reg.oob;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                out_next   = ent_reg.oob ? '0 : rdata;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        val_reg  <= val_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        c_reg    <= c_next;
        addr_reg <= addr_next;
        out_reg  <= out_next;
    end

    assign done          = done_reg;
    assign rotated_value = out_reg;

endmodule

// File: rtl/grid_ring_rotation_remap.sv
// ----------------------------------------------------------------------------
// grid_ring_rotation_remap
// Grid store with rotated reads of its concentric rings.
// ----------------------------------------------------------------------------
// usage:
//   a request is taken on a rising edge with start high and busy low. kind 0
//   stores value at (row, col) and returns nothing; kind 1 returns the value
//   at (row, col) of the grid with every ring turned counter-clockwise by
//   shift_amount steps.
//   the result appears on rotated_value for one cycle with done high; the
//   receiver cannot stall, so done is never held.
//   requests are classified on entry and held in a two-entry queue; busy is
//   high while that queue is full.
//   a ring read runs the bit-serial remainder unit (shift modulo ring length,
//   which sets the sustained rate), then fold, remap, address and the
//   registered memory read; other reads run address and read only, writes
//   address and write. the user writes configuration (cfg_we, cfg_index,
//   cfg_data) only while idle; the block does not enforce this. reset clears
//   the queue and control; sizes return to 64 x 64, shift to 0. memory
//   contents are not cleared; read only cells that were written.
// ----------------------------------------------------------------------------
module grid_ring_rotation_remap #(
    parameter int MAX_ROWS   = grr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = grr_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = grr_pkg::DEF_DATA_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           kind,
    input  logic [grr_pkg::IDX_W-1:0]      row,
    input  logic [grr_pkg::IDX_W-1:0]      col,
    input  logic [DATA_WIDTH-1:0]          value,
    output logic                           done,
    output logic [DATA_WIDTH-1:0]          rotated_value,
    input  logic                           cfg_we,
    input  logic [grr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [grr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import grr_pkg::*;

`include "assert_macros.svh"

    localparam int QW = $bits(entry_t) + DATA_WIDTH;

    logic [CRD_W-1:0]   num_rows_reg, num_cols_reg;
    logic [SHIFT_W-1:0] shift_reg;
    entry_t             f_ent, q_ent;
    logic               q_push, q_pop, q_full, q_empty;
    logic [QW-1:0]      q_dout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= CRD_W'(64);
            num_cols_reg <= CRD_W'(64);
            shift_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_ROWS:     num_rows_reg <= cfg_data[CRD_W-1:0];
                CFG_NUM_COLS:     num_cols_reg <= cfg_data[CRD_W-1:0];
                CFG_SHIFT_AMOUNT: shift_reg    <= cfg_data[SHIFT_W-1:0];
                default:          ;
            endcase
        end
    end

    grr_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .num_rows (num_rows_reg),
        .num_cols (num_cols_reg),
        .kind     (kind),
        .row      (row),
        .col      (col),
        .ent      (f_ent)
    );

    assign busy   = q_full;
    assign q_push = start && !q_full;

    grr_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({f_ent, value}),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    assign q_ent = q_dout[QW-1:DATA_WIDTH];

    grr_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .shift_amount  (shift_reg),
        .q_empty       (q_empty),
        .q_ent         (q_ent),
        .q_value       (q_dout[DATA_WIDTH-1:0]),
        .q_pop         (q_pop),
        .done          (done),
        .rotated_value (rotated_value)
    );

    `GRR_ASSERT_NEXT(a_done_single, done, !done)
    `GRR_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty)
    `GRR_ASSERT_IMP(a_empty_not_full, q_empty, !q_full)

endmodule
